[design/mpc_pkg.sv]
// mpc_pkg: shared constants for the masked pearson correlation block
// no dependencies
package mpc_pkg;
   localparam int SampleBits = 16;
   localparam int MaxPairs   = 65536;
   localparam int CountBits  = $clog2(MaxPairs + 1);
   localparam int SumBits    = 32;
   localparam int SqBits     = 47;
   localparam int CrossBits  = 48;
   localparam int AccBits    = 64;
   localparam int MulBits    = 32;
   localparam int StepBits   = 5;
   localparam int CoefBits   = 16;
   localparam int CoefMax    = 32767;
   localparam int NormBit    = 31;
   localparam int ClampBit   = 40;
   localparam int FracBits   = 15;
   localparam int RootSteps  = 32;
endpackage

[design/mpc_alu.sv]
// mpc_alu: shared 64-bit add/subtract unit with carry out
// depends on mpc_pkg
module mpc_alu (
   input  logic [mpc_pkg::AccBits-1:0] op_a,
   input  logic [mpc_pkg::AccBits-1:0] op_b,
   input  logic                        op_sub,
   output logic [mpc_pkg::AccBits:0]   result
);
   import mpc_pkg::*;

   logic [AccBits:0] b_ext;

   assign b_ext  = op_sub ? {1'b0, ~op_b} : {1'b0, op_b};
   // for subtract, top bit high means op_a >= op_b
   assign result = {1'b0, op_a} + b_ext + {{AccBits{1'b0}}, op_sub};
endmodule

[design/masked_pearson_correlation.sv]
// masked_pearson_correlation: pairwise complete pearson coefficient, top level
// depends on mpc_pkg and mpc_alu
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  x, y samples, missing flags, last flag
//   rsp      out        rsp_valid/rsp_stall  coefficient, valid flag, pair count
//   csr      in         csr_valid/csr_ready  min_pairs
//
// a skipped pair needs no product; a present pair runs three 16-step shift-add products
// the last pair adds the variance, covariance and product multiplies, normalize, 32-step root, 16-step divide
// every product, root and divide step goes through the one 64-bit adder; req_stall is high while it is busy
// reset clears the sums, sets min_pairs to 3 and empties the output register
// a finished word waits for a stalled rsp side before the block takes the next pair
module masked_pearson_correlation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [mpc_pkg::SampleBits-1:0] req_x_sample,
   input  logic signed [mpc_pkg::SampleBits-1:0] req_y_sample,
   input  logic                               req_x_missing,
   input  logic                               req_y_missing,
   input  logic                               req_last_pair,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mpc_pkg::CoefBits-1:0] rsp_coefficient,
   output logic                               rsp_coefficient_valid,
   output logic [mpc_pkg::CountBits-1:0]      rsp_pair_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mpc_pkg::CountBits-1:0]      csr_min_pairs
);
   import mpc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_XX, ST_MUL_YY, ST_MUL_XY, ST_BEGIN, ST_NXX, ST_SQX, ST_NYY,
      ST_SQY, ST_NXY, ST_SXY, ST_CHECK, ST_NORM, ST_PROD, ST_SQRT, ST_NUM, ST_DIV,
      ST_SIGN, ST_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [CountBits-1:0]    min_pairs_ff, min_pairs_in;
   logic [CountBits-1:0]    count_ff, count_in;
   logic [SumBits-1:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic [SqBits-1:0]       sxx_ff, sxx_in, syy_ff, syy_in;
   logic [CrossBits-1:0]    sxy_ff, sxy_in;
   logic [SampleBits-1:0]   x_ff, x_in, y_ff, y_in;
   logic                    last_ff, last_in;
   logic [AccBits-1:0]      acc_ff, acc_in, mcand_ff, mcand_in;
   logic [MulBits-1:0]      mplier_ff, mplier_in;
   logic [StepBits-1:0]     step_ff, step_in;
   logic [AccBits-1:0]      var_x_ff, var_x_in, var_y_ff, var_y_in, cov_ff, cov_in;
   logic [AccBits-1:0]      root_ff, root_in, bit_ff, bit_in;
   logic                    neg_ff, neg_in, valid_ff, valid_in;
   logic [CoefBits-1:0]     quot_ff, quot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CoefBits-1:0]     rsp_coef_ff, rsp_coef_in;
   logic                    rsp_cvalid_ff, rsp_cvalid_in;
   logic [CountBits-1:0]    rsp_count_ff, rsp_count_in;

   logic [AccBits-1:0]      alu_a, alu_b;
   logic                    alu_sub;
   logic [AccBits:0]        alu_sum;
   logic                    mul_state, mul_neg, mul_done;
   logic [AccBits-1:0]      acc_step, mag_clamped;
   logic                    present;
   logic [CoefBits-1:0]     quot_next;

   mpc_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .result (alu_sum)
   );

   assign req_stall             = (state_ff != ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_coefficient       = rsp_coef_ff;
   assign rsp_coefficient_valid = rsp_cvalid_ff;
   assign rsp_pair_count        = rsp_count_ff;

   assign mul_state = (state_ff == ST_MUL_XX) || (state_ff == ST_MUL_YY) ||
                      (state_ff == ST_MUL_XY) || (state_ff == ST_NXX) ||
                      (state_ff == ST_SQX) || (state_ff == ST_NYY) ||
                      (state_ff == ST_SQY) || (state_ff == ST_NXY) ||
                      (state_ff == ST_SXY) || (state_ff == ST_PROD);
   assign mul_neg   = (state_ff == ST_SQX) || (state_ff == ST_SQY) || (state_ff == ST_SXY);
   assign mul_done  = (step_ff == '0);
   assign acc_step  = mplier_ff[0] ? alu_sum[AccBits-1:0] : acc_ff;
   assign present   = !req_x_missing && !req_y_missing;
   assign mag_clamped = (cov_ff > (AccBits'(1) << ClampBit)) ? (AccBits'(1) << ClampBit)
                                                             : cov_ff;
   assign quot_next = {quot_ff[CoefBits-2:0], alu_sum[AccBits]};

   always_comb begin
      alu_a   = acc_ff;
      alu_b   = mcand_ff;
      alu_sub = mul_neg ^ mul_done;
      case (state_ff)
         ST_CHECK: begin
            alu_a   = '0;
            alu_b   = cov_ff;
            alu_sub = 1'b1;
         end
         ST_SQRT: begin
            alu_a   = var_x_ff;
            alu_b   = root_ff | bit_ff;
            alu_sub = 1'b1;
         end
         ST_NUM: begin
            alu_a   = mag_clamped << FracBits;
            alu_b   = root_ff >> 1;
            alu_sub = 1'b0;
         end
         ST_DIV: begin
            alu_a   = var_x_ff;
            alu_b   = mcand_ff;
            alu_sub = 1'b1;
         end
         ST_SIGN: begin
            alu_a   = '0;
            alu_b   = {{(AccBits-CoefBits){1'b0}}, quot_ff};
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      min_pairs_in  = csr_valid ? csr_min_pairs : min_pairs_ff;
      count_in      = count_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sxx_in        = sxx_ff;
      syy_in        = syy_ff;
      sxy_in        = sxy_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      step_in       = step_ff;
      var_x_in      = var_x_ff;
      var_y_in      = var_y_ff;
      cov_in        = cov_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      neg_in        = neg_ff;
      valid_in      = valid_ff;
      quot_in       = quot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_coef_in   = rsp_coef_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_count_in  = rsp_count_ff;

      if (mul_state) begin
         acc_in    = acc_step;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         step_in   = step_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_x_sample;
               y_in    = req_y_sample;
               last_in = req_last_pair;
               if (present && (count_ff != CountBits'(MaxPairs))) begin
                  count_in  = count_ff + 1'b1;
                  sx_in     = sx_ff + {{(SumBits-SampleBits){req_x_sample[SampleBits-1]}},
                                       req_x_sample};
                  sy_in     = sy_ff + {{(SumBits-SampleBits){req_y_sample[SampleBits-1]}},
                                       req_y_sample};
                  acc_in    = {{(AccBits-SqBits){1'b0}}, sxx_ff};
                  mcand_in  = {{(AccBits-SampleBits){req_x_sample[SampleBits-1]}},
                               req_x_sample};
                  mplier_in = {{(MulBits-SampleBits){req_x_sample[SampleBits-1]}},
                               req_x_sample};
                  step_in   = StepBits'(SampleBits - 1);
                  state_in  = ST_MUL_XX;
               end else if (req_last_pair) begin
                  state_in = ST_BEGIN;
               end
            end
         end
         ST_MUL_XX: begin
            if (mul_done) begin
               sxx_in    = acc_step[SqBits-1:0];
               acc_in    = {{(AccBits-SqBits){1'b0}}, syy_ff};
               mcand_in  = {{(AccBits-SampleBits){y_ff[SampleBits-1]}}, y_ff};
               mplier_in = {{(MulBits-SampleBits){y_ff[SampleBits-1]}}, y_ff};
               step_in   = StepBits'(SampleBits - 1);
               state_in  = ST_MUL_YY;
            end
         end
         ST_MUL_YY: begin
            if (mul_done) begin
               syy_in    = acc_step[SqBits-1:0];
               acc_in    = {{(AccBits-CrossBits){sxy_ff[CrossBits-1]}}, sxy_ff};
               mcand_in  = {{(AccBits-SampleBits){x_ff[SampleBits-1]}}, x_ff};
               mplier_in = {{(MulBits-SampleBits){y_ff[SampleBits-1]}}, y_ff};
               step_in   = StepBits'(SampleBits - 1);
               state_in  = ST_MUL_XY;
            end
         end
         ST_MUL_XY: begin
            if (mul_done) begin
               sxy_in   = acc_step[CrossBits-1:0];
               state_in = last_ff ? ST_BEGIN : ST_IDLE;
            end
         end
         ST_BEGIN: begin
            acc_in    = '0;
            mcand_in  = {{(AccBits-SqBits){1'b0}}, sxx_ff};
            mplier_in = {{(MulBits-CountBits){1'b0}}, count_ff};
            step_in   = StepBits'(CountBits);
            state_in  = ST_NXX;
         end
         ST_NXX: begin
            if (mul_done) begin
               mcand_in  = {{(AccBits-SumBits){sx_ff[SumBits-1]}}, sx_ff};
               mplier_in = sx_ff;
               step_in   = StepBits'(MulBits - 1);
               state_in  = ST_SQX;
            end
         end
         ST_SQX: begin
            if (mul_done) begin
               var_x_in  = acc_step;
               acc_in    = '0;
               mcand_in  = {{(AccBits-SqBits){1'b0}}, syy_ff};
               mplier_in = {{(MulBits-CountBits){1'b0}}, count_ff};
               step_in   = StepBits'(CountBits);
               state_in  = ST_NYY;
            end
         end
         ST_NYY: begin
            if (mul_done) begin
               mcand_in  = {{(AccBits-SumBits){sy_ff[SumBits-1]}}, sy_ff};
               mplier_in = sy_ff;
               step_in   = StepBits'(MulBits - 1);
               state_in  = ST_SQY;
            end
         end
         ST_SQY: begin
            if (mul_done) begin
               var_y_in  = acc_step;
               acc_in    = '0;
               mcand_in  = {{(AccBits-CrossBits){sxy_ff[CrossBits-1]}}, sxy_ff};
               mplier_in = {{(MulBits-CountBits){1'b0}}, count_ff};
               step_in   = StepBits'(CountBits);
               state_in  = ST_NXY;
            end
         end
         ST_NXY: begin
            if (mul_done) begin
               mcand_in  = {{(AccBits-SumBits){sx_ff[SumBits-1]}}, sx_ff};
               mplier_in = sy_ff;
               step_in   = StepBits'(MulBits - 1);
               state_in  = ST_SXY;
            end
         end
         ST_SXY: begin
            if (mul_done) begin
               cov_in   = acc_step;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // wrapped variance counts as zero
            if (var_x_ff[AccBits-1]) var_x_in = '0;
            if (var_y_ff[AccBits-1]) var_y_in = '0;
            neg_in = cov_ff[AccBits-1];
            if (cov_ff[AccBits-1]) cov_in = alu_sum[AccBits-1:0];
            valid_in = (count_ff >= min_pairs_ff) &&
                       !var_x_ff[AccBits-1] && (var_x_ff != '0) &&
                       !var_y_ff[AccBits-1] && (var_y_ff != '0);
            quot_in  = '0;
            state_in = valid_in ? ST_NORM : ST_SIGN;
         end
         ST_NORM: begin
            if (var_x_ff[AccBits-1:NormBit] != '0) begin
               var_x_in = var_x_ff >> 2;
               cov_in   = cov_ff >> 1;
            end else if (var_y_ff[AccBits-1:NormBit] != '0) begin
               var_y_in = var_y_ff >> 2;
               cov_in   = cov_ff >> 1;
            end else begin
               acc_in    = '0;
               mcand_in  = var_x_ff;
               mplier_in = var_y_ff[MulBits-1:0];
               step_in   = StepBits'(MulBits - 1);
               state_in  = ST_PROD;
            end
         end
         ST_PROD: begin
            if (mul_done) begin
               var_x_in = acc_step;
               root_in  = '0;
               bit_in   = AccBits'(1) << (2 * (RootSteps - 1));
               step_in  = StepBits'(RootSteps - 1);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (alu_sum[AccBits]) begin
               var_x_in = alu_sum[AccBits-1:0];
               root_in  = (root_ff >> 1) | bit_ff;
            end else begin
               root_in  = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) state_in = ST_NUM;
         end
         ST_NUM: begin
            if (root_ff == '0) begin
               valid_in = 1'b0;
               quot_in  = '0;
               state_in = ST_SIGN;
            end else begin
               var_x_in = alu_sum[AccBits-1:0];
               mcand_in = root_ff << FracBits;
               quot_in  = '0;
               step_in  = StepBits'(FracBits);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (alu_sum[AccBits]) var_x_in = alu_sum[AccBits-1:0];
            mcand_in = mcand_ff >> 1;
            quot_in  = quot_next;
            step_in  = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (quot_next[CoefBits-1]) quot_in = CoefBits'(CoefMax);
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (neg_ff) quot_in = alu_sum[CoefBits-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_coef_in   = quot_ff;
               rsp_cvalid_in = valid_ff;
               rsp_count_in  = count_ff;
               count_in      = '0;
               sx_in         = '0;
               sy_in         = '0;
               sxx_in        = '0;
               syy_in        = '0;
               sxy_in        = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_pairs_ff <= CountBits'(3);
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         syy_ff       <= '0;
         sxy_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_pairs_ff <= min_pairs_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         syy_ff       <= syy_in;
         sxy_ff       <= sxy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      last_ff       <= last_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      step_ff       <= step_in;
      var_x_ff      <= var_x_in;
      var_y_ff      <= var_y_in;
      cov_ff        <= cov_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      neg_ff        <= neg_in;
      valid_ff      <= valid_in;
      quot_ff       <= quot_in;
      rsp_coef_ff   <= rsp_coef_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_count_ff  <= rsp_count_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(MaxPairs))
      else $error("pair count beyond limit");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_cvalid_ff |-> rsp_coef_ff == '0)
      else $error("invalid word carries nonzero coefficient");

   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_coef_ff != {1'b1, {(CoefBits-1){1'b0}}})
      else $error("coefficient not saturated");

   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && state_in == ST_IDLE |=> count_ff == '0 && rsp_valid_ff)
      else $error("sums not cleared after result");
endmodule
